[rtl/core/bitmap_glyph_lookup_scaler_top_defines.svh]
// ----------------------------------------------------------------------------
// Glyph lookup scaler assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_LOOKUP_SCALER_TOP_DEFINES_SVH
`define BITMAP_GLYPH_LOOKUP_SCALER_TOP_DEFINES_SVH

// same-cycle implication
`define BGLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bgls_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph lookup scaler package
// Field widths, operation and register codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgls_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 13;
    localparam int SROW_W     = 5;
    localparam int WORD_W     = 32;
    localparam int CODE_W     = 21;
    localparam int ROWS_W     = 7;
    localparam int EM_W       = 8;
    localparam int ROWNUM_W   = 6;
    localparam int DIM_W      = 6;
    localparam int TOTAL_W    = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int REM_W      = 7;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_WR_INDEX = 2'd0;
    localparam t_op OP_WR_ROW   = 2'd1;
    localparam t_op OP_RENDER   = 2'd2;

    localparam t_cfg_idx CFG_CELL_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_CELL_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_GLYPH_TOTAL = 2'd2;

    localparam logic [DIM_W-1:0]   CELL_WIDTH_RST  = 6'd12;
    localparam logic [DIM_W-1:0]   CELL_HEIGHT_RST = 6'd12;
    localparam logic [TOTAL_W-1:0] GLYPH_TOTAL_RST = 14'd0;
    localparam logic [DIM_W-1:0]   CELL_WIDTH_MAX  = 6'd32;
    localparam logic [CODE_W-1:0]  ASCII_LIMIT     = 21'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_ROW_DIV,
        S_ROW_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/core/bgls_ram.sv]
// ----------------------------------------------------------------------------
// Glyph lookup scaler RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_glyph_lookup_scaler_top.sv]
// ----------------------------------------------------------------------------
// Bitmap glyph lookup scaler
// Sorted codepoint index search and scaled glyph row output.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when i_start is high and o_busy low.
//   Index and glyph row writes finish when taken and give no result.
//   A render item gives results on o_row_bits..o_last, one beat per o_valid
//   cycle; the receiver cannot stall, every beat must be taken.
//   A miss caught before the search (small codepoint, zero rows,
//   empty index, zero cell size) shows in the cycle after accept and o_busy
//   stays low. Otherwise each probe of the index RAM passes through S_SRCH
//   and S_CMP, then each output row passes through the glyph RAM read and
//   the bit reversal, after the steps of the shared compare/subtract unit
//   that scales the row number; over a request those steps number fewer
//   than cell_height.
//   Reset (synchronous, active low) loads cell width 12, cell height 12,
//   glyph total 0 and idles the sequencer. The RAMs are not cleared and no
//   clearing pass runs; entries must be written before they are read.
//   Configuration writes are taken in any cycle, and are meant for idle time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_glyph_lookup_scaler_top #(
    parameter int MAX_GLYPHS      = 8192,
    parameter int MAX_CELL_HEIGHT = 32,
    parameter int MAX_OUT_ROWS    = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [bgls_pkg::OP_W-1:0]        i_operation,
    input  wire logic [bgls_pkg::SLOT_W-1:0]      i_slot,
    input  wire logic [bgls_pkg::SROW_W-1:0]      i_source_row,
    input  wire logic [bgls_pkg::WORD_W-1:0]      i_row_word,
    input  wire logic [bgls_pkg::CODE_W-1:0]      i_codepoint,
    input  wire logic [bgls_pkg::ROWS_W-1:0]      i_out_rows,
    input  wire logic [bgls_pkg::EM_W-1:0]        i_em_height,
    input  wire logic                             i_want_rows,
    input  wire logic                             i_cfg_we,
    input  wire logic [bgls_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bgls_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                  o_busy,
    output logic                                  o_valid,
    output logic      [bgls_pkg::WORD_W-1:0]      o_row_bits,
    output logic      [bgls_pkg::ROWNUM_W-1:0]    o_row_number,
    output logic                                  o_found,
    output logic      [bgls_pkg::EM_W-1:0]        o_height_back,
    output logic                                  o_last
);

    import bgls_pkg::*;

    localparam int IDX_AW    = $clog2(MAX_GLYPHS);
    localparam int CNT_W     = IDX_AW + 1;
    localparam int ROW_AW    = $clog2(MAX_CELL_HEIGHT);
    localparam int GLY_DEPTH = MAX_GLYPHS << ROW_AW;
    localparam int GLY_AW    = IDX_AW + ROW_AW;

    localparam logic [DIM_W-1:0]  H_MAX = DIM_W'(MAX_CELL_HEIGHT);
    localparam logic [CNT_W-1:0]  N_MAX = CNT_W'(MAX_GLYPHS);
    localparam logic [ROWS_W-1:0] R_MAX = ROWS_W'(MAX_OUT_ROWS);

    // configuration
    logic [DIM_W-1:0]   r_cell_width;
    logic [DIM_W-1:0]   r_cell_height;
    logic [TOTAL_W-1:0] r_glyph_total;

    // sequencer and datapath
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [IDX_AW-1:0]   r_pos, n_pos;
    logic [CODE_W-1:0]   r_key, n_key;
    logic [EM_W-1:0]     r_em, n_em;
    logic                r_want, n_want;
    logic [DIM_W-1:0]    r_w, n_w;
    logic [DIM_W-1:0]    r_h, n_h;
    logic [ROWS_W-1:0]   r_rows, n_rows;
    logic [ROWS_W-1:0]   r_y, n_y;
    logic [ROW_AW-1:0]   r_q, n_q;
    logic [REM_W-1:0]    r_rem, n_rem;

    // result register
    logic                r_valid, n_valid;
    logic [WORD_W-1:0]   r_row_bits, n_row_bits;
    logic [ROWNUM_W-1:0] r_row_number, n_row_number;
    logic                r_found, n_found;
    logic [EM_W-1:0]     r_height, n_height;
    logic                r_last, n_last;

    logic                w_accept;
    logic                w_slot_ok;
    logic                w_idx_we;
    logic                w_gly_we;
    logic [CODE_W-1:0]   w_idx_rdata;
    logic [WORD_W-1:0]   w_gly_rdata;
    logic [CNT_W-1:0]    w_mid;
    logic [DIM_W-1:0]    w_cw_eff;
    logic [DIM_W-1:0]    w_ch_eff;
    logic [CNT_W-1:0]    w_n_eff;
    logic [ROWS_W-1:0]   w_rows_eff;
    logic                w_early_miss;
    logic [2:0]          w_nbytes;
    logic [4:0]          w_shift;
    logic [WORD_W-1:0]   w_aligned;
    logic [WORD_W-1:0]   w_rev;
    logic [WORD_W:0]     w_mask;
    logic [WORD_W-1:0]   w_bits;

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_row_bits    = r_row_bits;
    assign o_row_number  = r_row_number;
    assign o_found       = r_found;
    assign o_height_back = r_height;
    assign o_last        = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= CELL_WIDTH_RST;
            r_cell_height <= CELL_HEIGHT_RST;
            r_glyph_total <= GLYPH_TOTAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_data[DIM_W-1:0];
                CFG_CELL_HEIGHT: r_cell_height <= i_cfg_data[DIM_W-1:0];
                CFG_GLYPH_TOTAL: r_glyph_total <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    // load path
    assign w_accept  = i_start && !o_busy;
    assign w_slot_ok = (32'(i_slot) < 32'(MAX_GLYPHS));
    assign w_idx_we  = w_accept && (i_operation == OP_WR_INDEX) && w_slot_ok;
    assign w_gly_we  = w_accept && (i_operation == OP_WR_ROW) && w_slot_ok
                       && (32'(i_source_row) < 32'(MAX_CELL_HEIGHT));

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    bgls_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MAX_GLYPHS)
    ) u_index_ram (
        .i_clk   (i_clk),
        .i_we    (w_idx_we),
        .i_waddr (IDX_AW'(i_slot)),
        .i_wdata (i_codepoint),
        .i_raddr (w_mid[IDX_AW-1:0]),
        .o_rdata (w_idx_rdata)
    );

    bgls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GLY_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (w_gly_we),
        .i_waddr ({IDX_AW'(i_slot), ROW_AW'(i_source_row)}),
        .i_wdata (i_row_word),
        .i_raddr (GLY_AW'({r_pos, r_q})),
        .o_rdata (w_gly_rdata)
    );

    // effective register values at accept
    assign w_cw_eff   = (r_cell_width > CELL_WIDTH_MAX) ? CELL_WIDTH_MAX : r_cell_width;
    assign w_ch_eff   = (r_cell_height > H_MAX) ? H_MAX : r_cell_height;
    assign w_n_eff    = (32'(r_glyph_total) > 32'(MAX_GLYPHS)) ? N_MAX
                                                               : CNT_W'(r_glyph_total);
    assign w_rows_eff = (i_out_rows > R_MAX) ? R_MAX : i_out_rows;
    assign w_early_miss = (w_n_eff == '0) || (w_cw_eff == '0) || (w_ch_eff == '0)
                          || (i_codepoint < ASCII_LIMIT) || (w_rows_eff == '0);

    // row reversal: top used bit becomes pixel 0
    always_comb begin
        w_nbytes  = 3'((r_w + 6'd7) >> 3);
        w_shift   = 5'({2'b00, 3'd4 - w_nbytes} << 3);
        w_aligned = w_gly_rdata << w_shift;
        for (int i = 0; i < WORD_W; i++) begin
            w_rev[i] = w_aligned[WORD_W-1-i];
        end
        w_mask = (33'd1 << r_w) - 33'd1;
        w_bits = w_rev & w_mask[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_em         <= n_em;
        r_want       <= n_want;
        r_w          <= n_w;
        r_h          <= n_h;
        r_rows       <= n_rows;
        r_y          <= n_y;
        r_q          <= n_q;
        r_rem        <= n_rem;
        r_row_bits   <= n_row_bits;
        r_row_number <= n_row_number;
        r_found      <= n_found;
        r_height     <= n_height;
        r_last       <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_pos        = r_pos;
        n_key        = r_key;
        n_em         = r_em;
        n_want       = r_want;
        n_w          = r_w;
        n_h          = r_h;
        n_rows       = r_rows;
        n_y          = r_y;
        n_q          = r_q;
        n_rem        = r_rem;
        n_valid      = 1'b0;
        n_row_bits   = r_row_bits;
        n_row_number = r_row_number;
        n_found      = r_found;
        n_height     = r_height;
        n_last       = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_RENDER)) begin
                    n_key  = i_codepoint;
                    n_em   = i_em_height;
                    n_want = i_want_rows;
                    n_w    = w_cw_eff;
                    n_h    = w_ch_eff;
                    n_rows = w_rows_eff;
                    n_lo   = '0;
                    n_hi   = w_n_eff;
                    if (w_early_miss) begin
                        n_valid      = 1'b1;
                        n_row_bits   = '0;
                        n_row_number = '0;
                        n_found      = 1'b0;
                        n_height     = '0;
                        n_last       = 1'b1;
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else begin
                    n_valid      = 1'b1;
                    n_row_bits   = '0;
                    n_row_number = '0;
                    n_found      = 1'b0;
                    n_height     = '0;
                    n_last       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CMP: begin
                priority if (w_idx_rdata == r_key) begin
                    n_pos = w_mid[IDX_AW-1:0];
                    if (!r_want) begin
                        n_valid      = 1'b1;
                        n_row_bits   = '0;
                        n_row_number = '0;
                        n_found      = 1'b1;
                        n_height     = r_em;
                        n_last       = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_y     = '0;
                        n_q     = '0;
                        n_rem   = '0;
                        n_state = S_ROW_DIV;
                    end
                end else if (w_idx_rdata < r_key) begin
                    n_lo    = w_mid + CNT_W'(1);
                    n_state = S_SRCH;
                end else begin
                    n_hi    = w_mid;
                    n_state = S_SRCH;
                end
            end
            S_ROW_DIV: begin
                // rem tracks y*h - q*rows; q ends as y*h/rows, always below h
                if (r_rem >= r_rows) begin
                    n_rem = r_rem - r_rows;
                    n_q   = r_q + ROW_AW'(1);
                end else begin
                    n_state = S_ROW_OUT;
                end
            end
            S_ROW_OUT: begin
                n_valid      = 1'b1;
                n_row_bits   = w_bits;
                n_row_number = r_y[ROWNUM_W-1:0];
                n_found      = 1'b1;
                n_height     = r_em;
                if (r_y + ROWS_W'(1) == r_rows) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_last  = 1'b0;
                    n_y     = r_y + ROWS_W'(1);
                    n_rem   = r_rem + REM_W'(r_h);
                    n_state = S_ROW_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/bgls_checker.sv]
// ----------------------------------------------------------------------------
// Glyph lookup scaler checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_glyph_lookup_scaler_top_defines.svh"

module bgls_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_start,
    input wire logic [bgls_pkg::OP_W-1:0]        i_operation,
    input wire logic                             o_busy,
    input wire logic                             o_valid,
    input wire logic [bgls_pkg::WORD_W-1:0]      o_row_bits,
    input wire logic [bgls_pkg::ROWNUM_W-1:0]    o_row_number,
    input wire logic                             o_found,
    input wire logic [bgls_pkg::EM_W-1:0]        o_height_back,
    input wire logic                             o_last
);

    import bgls_pkg::*;

    // a miss is a single, all-zero final beat
    `BGLS_ASSERT_NOW(a_miss_beat, i_clk, i_rst_n, o_valid && !o_found, o_last && (o_height_back == '0) && (o_row_bits == '0) && (o_row_number == '0), "miss beat malformed")

    // more rows pending keeps the command channel closed
    `BGLS_ASSERT_NOW(a_busy_mid_request, i_clk, i_rst_n, o_valid && !o_last, o_busy, "idle with rows pending")

    // row beats never come back to back
    `BGLS_ASSERT_NEXT(a_row_gap, i_clk, i_rst_n, o_valid && !o_last, !o_valid, "row beats back to back")

    // loads and unused codes finish at once and give no beat
    `BGLS_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_start && !o_busy && (i_operation != OP_RENDER), !o_valid && !o_busy, "load gave a beat")

endmodule

bind bitmap_glyph_lookup_scaler_top bgls_checker u_bgls_checker (.*);

`default_nettype wire
